FILE: hdl/mua_pkg.sv
// Shared types and constants for the memory usage accounting block.
package mua_pkg;

  localparam int BYTE_COUNTER_BITS_DEF  = 40;
  localparam int EVENT_COUNTER_BITS_DEF = 32;

  localparam int BYTE_FIELD_W  = 40;
  localparam int EVENT_FIELD_W = 32;
  localparam int SIZE_W        = 32;
  localparam int OP_W          = 2;
  localparam int KIND_W        = 3;
  localparam int CFG_W         = 40;
  localparam int CFG_IDX_W     = 1;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 368;

  localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd2;
  localparam logic [OP_W-1:0] OP_FAILURE = 2'd3;

  localparam logic [KIND_W-1:0] POOL_SMALL  = 3'd0;
  localparam logic [KIND_W-1:0] POOL_MEDIUM = 3'd1;
  localparam logic [KIND_W-1:0] POOL_LARGE  = 3'd2;
  localparam logic [KIND_W-1:0] POOL_HUGE   = 3'd3;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_NOT_INIT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_TOTAL    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APERTURE_TOTAL = 1'd1;

  localparam logic [CFG_W-1:0] VIDEO_TOTAL_RST    = 40'd268435456;
  localparam logic [CFG_W-1:0] APERTURE_TOTAL_RST = 40'd134217728;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic              video;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
  } event_t;

  typedef struct packed {
    logic [CFG_W-1:0] video_total;
    logic [CFG_W-1:0] aperture_total;
  } totals_t;

  typedef struct packed {
    logic                     status;
    logic [BYTE_FIELD_W-1:0]  video_used;
    logic [BYTE_FIELD_W-1:0]  video_free;
    logic [BYTE_FIELD_W-1:0]  video_peak;
    logic [BYTE_FIELD_W-1:0]  aperture_used;
    logic [BYTE_FIELD_W-1:0]  aperture_free;
    logic [EVENT_FIELD_W-1:0] active_count;
    logic [EVENT_FIELD_W-1:0] surface_total;
    logic [EVENT_FIELD_W-1:0] texture_total;
    logic [EVENT_FIELD_W-1:0] cursor_total;
    logic [EVENT_FIELD_W-1:0] failure_total;
  } result_t;

endpackage

FILE: hdl/mua_cfg.sv
// Configuration registers: video and aperture total byte counts.
module mua_cfg
  import mua_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output totals_t              totals
);

  logic [CFG_W-1:0] video_total_r;
  logic [CFG_W-1:0] aperture_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      video_total_r    <= VIDEO_TOTAL_RST;
      aperture_total_r <= APERTURE_TOTAL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIDEO_TOTAL:    video_total_r    <= cfg_data;
        REG_APERTURE_TOTAL: aperture_total_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign totals.video_total    = video_total_r;
  assign totals.aperture_total = aperture_total_r;

endmodule

FILE: hdl/mua_core.sv
// Accounting state and its combinational update for each event, registered on fire.
module mua_core
  import mua_pkg::*;
#(
  parameter int BYTE_COUNTER_BITS  = BYTE_COUNTER_BITS_DEF,
  parameter int EVENT_COUNTER_BITS = EVENT_COUNTER_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  event_t  ev,
  input  totals_t totals,
  output result_t res
);

  localparam int BW = BYTE_COUNTER_BITS;
  localparam int EW = EVENT_COUNTER_BITS;

  logic          ready_r,        ready_nxt;
  logic [BW-1:0] vid_used_r,     vid_used_nxt;
  logic [BW-1:0] vid_free_r,     vid_free_nxt;
  logic [BW-1:0] vid_peak_r,     vid_peak_nxt;
  logic [BW-1:0] ap_used_r,      ap_used_nxt;
  logic [BW-1:0] ap_free_r,      ap_free_nxt;
  logic [EW-1:0] active_r,       active_nxt;
  logic [EW-1:0] surface_r,      surface_nxt;
  logic [EW-1:0] texture_r,      texture_nxt;
  logic [EW-1:0] cursor_r,       cursor_nxt;
  logic [EW-1:0] failure_r,      failure_nxt;
  logic          status;

  function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] a,
                                            input logic [SIZE_W-1:0] b);
    logic [BW:0] sum;
    sum = {1'b0, a} + (BW+1)'(b);
    return sum[BW] ? {BW{1'b1}} : sum[BW-1:0];
  endfunction

  function automatic logic [EW-1:0] sat_inc(input logic [EW-1:0] a);
    return (a == {EW{1'b1}}) ? a : a + EW'(1);
  endfunction

  // totals wider than the counters saturate at load
  function automatic logic [BW-1:0] clamp_total(input logic [CFG_W-1:0] t);
    logic [BW+CFG_W-1:0] ext;
    ext = {{BW{1'b0}}, t};
    return (ext > {{CFG_W{1'b0}}, {BW{1'b1}}}) ? {BW{1'b1}} : ext[BW-1:0];
  endfunction

  function automatic logic [BYTE_FIELD_W-1:0] byte_field(input logic [BW-1:0] v);
    logic [BW+BYTE_FIELD_W-1:0] ext;
    ext = {{BYTE_FIELD_W{1'b0}}, v};
    return ext[BYTE_FIELD_W-1:0];
  endfunction

  function automatic logic [EVENT_FIELD_W-1:0] event_field(input logic [EW-1:0] v);
    logic [EW+EVENT_FIELD_W-1:0] ext;
    ext = {{EVENT_FIELD_W{1'b0}}, v};
    return ext[EVENT_FIELD_W-1:0];
  endfunction

  always_comb begin
    ready_nxt    = ready_r;
    vid_used_nxt = vid_used_r;
    vid_free_nxt = vid_free_r;
    vid_peak_nxt = vid_peak_r;
    ap_used_nxt  = ap_used_r;
    ap_free_nxt  = ap_free_r;
    active_nxt   = active_r;
    surface_nxt  = surface_r;
    texture_nxt  = texture_r;
    cursor_nxt   = cursor_r;
    failure_nxt  = failure_r;
    status       = STATUS_OK;

    if (ev.op == OP_INIT) begin
      ready_nxt    = 1'b1;
      vid_used_nxt = '0;
      vid_peak_nxt = '0;
      ap_used_nxt  = '0;
      active_nxt   = '0;
      surface_nxt  = '0;
      texture_nxt  = '0;
      cursor_nxt   = '0;
      failure_nxt  = '0;
      vid_free_nxt = clamp_total(totals.video_total);
      ap_free_nxt  = clamp_total(totals.aperture_total);
    end else if (!ready_r) begin
      status = STATUS_NOT_INIT;
    end else begin
      unique case (ev.op)
        OP_ALLOC: begin
          if (ev.video) begin
            vid_used_nxt = sat_add(vid_used_r, ev.size);
            if (vid_free_r >= BW'(ev.size)) vid_free_nxt = vid_free_r - BW'(ev.size);
            if (vid_used_nxt > vid_peak_r) vid_peak_nxt = vid_used_nxt;
          end else begin
            ap_used_nxt = sat_add(ap_used_r, ev.size);
            if (ap_free_r >= BW'(ev.size)) ap_free_nxt = ap_free_r - BW'(ev.size);
          end
          active_nxt = sat_inc(active_r);
          case (ev.kind)
            POOL_LARGE, POOL_HUGE: surface_nxt = sat_inc(surface_r);
            POOL_MEDIUM:           texture_nxt = sat_inc(texture_r);
            POOL_SMALL:            cursor_nxt  = sat_inc(cursor_r);
            default: ;
          endcase
        end
        OP_FREE: begin
          if (ev.video) begin
            if (vid_used_r >= BW'(ev.size)) vid_used_nxt = vid_used_r - BW'(ev.size);
            vid_free_nxt = sat_add(vid_free_r, ev.size);
          end else begin
            if (ap_used_r >= BW'(ev.size)) ap_used_nxt = ap_used_r - BW'(ev.size);
            ap_free_nxt = sat_add(ap_free_r, ev.size);
          end
          if (active_r != '0) active_nxt = active_r - EW'(1);
        end
        default: failure_nxt = sat_inc(failure_r);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r    <= 1'b0;
      vid_used_r <= '0;
      vid_free_r <= '0;
      vid_peak_r <= '0;
      ap_used_r  <= '0;
      ap_free_r  <= '0;
      active_r   <= '0;
      surface_r  <= '0;
      texture_r  <= '0;
      cursor_r   <= '0;
      failure_r  <= '0;
    end else if (fire) begin
      ready_r    <= ready_nxt;
      vid_used_r <= vid_used_nxt;
      vid_free_r <= vid_free_nxt;
      vid_peak_r <= vid_peak_nxt;
      ap_used_r  <= ap_used_nxt;
      ap_free_r  <= ap_free_nxt;
      active_r   <= active_nxt;
      surface_r  <= surface_nxt;
      texture_r  <= texture_nxt;
      cursor_r   <= cursor_nxt;
      failure_r  <= failure_nxt;
    end
  end

  always_comb begin
    res.status        = status;
    res.video_used    = byte_field(vid_used_nxt);
    res.video_free    = byte_field(vid_free_nxt);
    res.video_peak    = byte_field(vid_peak_nxt);
    res.aperture_used = byte_field(ap_used_nxt);
    res.aperture_free = byte_field(ap_free_nxt);
    res.active_count  = event_field(active_nxt);
    res.surface_total = event_field(surface_nxt);
    res.texture_total = event_field(texture_nxt);
    res.cursor_total  = event_field(cursor_nxt);
    res.failure_total = event_field(failure_nxt);
  end

`ifndef SYNTHESIS
  a_peak_covers_used: assert property (@(posedge clk) disable iff (!rst_n)
    vid_used_r <= vid_peak_r)
    else $error("video used bytes above peak");

  a_init_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev.op == OP_INIT |=> ready_r && vid_used_r == '0 && active_r == '0)
    else $error("init did not clear counters");

  a_not_ready_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !ready_r && ev.op != OP_INIT |=> $stable(active_r) && $stable(failure_r)
      && !ready_r)
    else $error("state changed before init");

  a_free_no_rise: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ev.op == OP_FREE |=> active_r <= $past(active_r))
    else $error("active count rose on free");
`endif

endmodule

FILE: hdl/memory_usage_accounting_top.sv
// Top level: input register, accounting core and output register.
//
//  channel | ports              | content
//  --------+--------------------+------------------------------------------
//  in      | in_tvalid/tready   | one memory event per item
//  out     | out_tvalid/tready  | status and counter snapshot per item
//  cfg     | cfg_we/index/data  | total byte registers, write only
//
// One item per cycle sustained while out_tready stays high. An accepted item sits
// in the input register, takes the counter update into the output register once
// that register is empty or being taken, and shows on out_tvalid from then on.
// The counter update is the only loop.
// Reset is synchronous on rst_n: counters clear, block not initialized.
// A stalled output holds its item; the input register still takes one more.
module memory_usage_accounting_top
  import mua_pkg::*;
#(
  parameter int BYTE_COUNTER_BITS  = BYTE_COUNTER_BITS_DEF,
  parameter int EVENT_COUNTER_BITS = EVENT_COUNTER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] in_video_domain, [3:1] pool_kind, [35:4] size_in_bytes
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] operation
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] status, [40:1] video_used, [80:41] video_free, [120:81] video_peak,
  // [160:121] aperture_used, [200:161] aperture_free, [232:201] active_count,
  // [264:233] surface_total, [296:265] texture_total, [328:297] cursor_total,
  // [360:329] failure_total
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic    in_valid_r;
  event_t  ev_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res;
  totals_t totals;
  logic    fire;

  assign fire      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || fire;

  mua_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .totals    (totals)
  );

  mua_core #(
    .BYTE_COUNTER_BITS  (BYTE_COUNTER_BITS),
    .EVENT_COUNTER_BITS (EVENT_COUNTER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .ev     (ev_r),
    .totals (totals),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (fire) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ev_r.op    <= in_tuser;
      ev_r.video <= in_tdata[0];
      ev_r.kind  <= in_tdata[3:1];
      ev_r.size  <= in_tdata[35:4];
    end
    if (fire) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0,
                       res_r.failure_total, res_r.cursor_total, res_r.texture_total,
                       res_r.surface_total, res_r.active_count,
                       res_r.aperture_free, res_r.aperture_used,
                       res_r.video_peak, res_r.video_free, res_r.video_used,
                       res_r.status};

endmodule

FILE: tb/sv/memory_usage_accounting_checker.sv
// Checker for the memory usage accounting block: tracks counters and compares snapshots.
module memory_usage_accounting_checker
  import mua_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [BYTE_FIELD_W-1:0]  BYTES_ALL_ONES  = '1;
  localparam logic [EVENT_FIELD_W-1:0] EVENTS_ALL_ONES = '1;

  logic [CFG_W-1:0] video_total_reg;
  logic [CFG_W-1:0] aperture_total_reg;

  logic                     initialized;
  logic [BYTE_FIELD_W-1:0]  vid_used, vid_free, vid_peak, apt_used, apt_free;
  logic [EVENT_FIELD_W-1:0] active_cnt, surface_cnt, texture_cnt, cursor_cnt, failure_cnt;

  result_t expected_snapshots[$];

  string field_names [11] = '{"status", "video_used", "video_free", "video_peak",
                              "aperture_used", "aperture_free", "active_count",
                              "surface_total", "texture_total", "cursor_total",
                              "failure_total"};

  function automatic logic [BYTE_FIELD_W-1:0] add_bytes_sat(
      logic [BYTE_FIELD_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [BYTE_FIELD_W:0] sum;
    sum = {1'b0, a} + {{(BYTE_FIELD_W-SIZE_W+1){1'b0}}, b};
    return sum[BYTE_FIELD_W] ? BYTES_ALL_ONES : sum[BYTE_FIELD_W-1:0];
  endfunction

  function automatic logic [EVENT_FIELD_W-1:0] bump_sat(logic [EVENT_FIELD_W-1:0] a);
    return (a == EVENTS_ALL_ONES) ? a : a + 1'b1;
  endfunction

  task automatic clear_counters();
    initialized = 1'b0;
    vid_used = '0; vid_free = '0; vid_peak = '0;
    apt_used = '0; apt_free = '0;
    active_cnt = '0; surface_cnt = '0; texture_cnt = '0;
    cursor_cnt = '0; failure_cnt = '0;
  endtask

  task automatic account_event(logic [OP_W-1:0] op, logic video,
                               logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size);
    result_t snap;
    logic    status;
    logic [BYTE_FIELD_W-1:0] size_w;
    size_w = {{(BYTE_FIELD_W-SIZE_W){1'b0}}, size};
    status = STATUS_OK;
    if (op == OP_INIT) begin
      clear_counters();
      // totals are already at the byte counter width, so no clamp is needed
      vid_free = video_total_reg;
      apt_free = aperture_total_reg;
      initialized = 1'b1;
    end else if (!initialized) begin
      status = STATUS_NOT_INIT;
    end else if (op == OP_ALLOC) begin
      if (video) begin
        vid_used = add_bytes_sat(vid_used, size);
        if (vid_free >= size_w) vid_free = vid_free - size_w;
        if (vid_used > vid_peak) vid_peak = vid_used;
      end else begin
        apt_used = add_bytes_sat(apt_used, size);
        if (apt_free >= size_w) apt_free = apt_free - size_w;
      end
      active_cnt = bump_sat(active_cnt);
      if (kind == POOL_LARGE || kind == POOL_HUGE) surface_cnt = bump_sat(surface_cnt);
      else if (kind == POOL_MEDIUM) texture_cnt = bump_sat(texture_cnt);
      else if (kind == POOL_SMALL) cursor_cnt = bump_sat(cursor_cnt);
    end else if (op == OP_FREE) begin
      if (video) begin
        if (vid_used >= size_w) vid_used = vid_used - size_w;
        vid_free = add_bytes_sat(vid_free, size);
      end else begin
        if (apt_used >= size_w) apt_used = apt_used - size_w;
        apt_free = add_bytes_sat(apt_free, size);
      end
      if (active_cnt != '0) active_cnt = active_cnt - 1'b1;
    end else begin
      failure_cnt = bump_sat(failure_cnt);
    end
    snap.status        = status;
    snap.video_used    = vid_used;
    snap.video_free    = vid_free;
    snap.video_peak    = vid_peak;
    snap.aperture_used = apt_used;
    snap.aperture_free = apt_free;
    snap.active_count  = active_cnt;
    snap.surface_total = surface_cnt;
    snap.texture_total = texture_cnt;
    snap.cursor_total  = cursor_cnt;
    snap.failure_total = failure_cnt;
    expected_snapshots.push_back(snap);
  endtask

  task automatic compare_snapshot(result_t exp, logic [OUT_DATA_W-1:0] got);
    logic [BYTE_FIELD_W-1:0] exp_f [11];
    logic [BYTE_FIELD_W-1:0] got_f;
    logic [BYTE_FIELD_W-1:0] mask;
    int lo;
    int w;
    exp_f = '{{39'd0, exp.status}, exp.video_used, exp.video_free, exp.video_peak,
              exp.aperture_used, exp.aperture_free,
              {8'd0, exp.active_count}, {8'd0, exp.surface_total},
              {8'd0, exp.texture_total}, {8'd0, exp.cursor_total},
              {8'd0, exp.failure_total}};
    lo = 0;
    for (int i = 0; i < 11; i++) begin
      w = (i == 0) ? 1 : ((i <= 5) ? BYTE_FIELD_W : EVENT_FIELD_W);
      mask = (w == BYTE_FIELD_W) ? BYTES_ALL_ONES : ((40'd1 << w) - 40'd1);
      got_f = BYTE_FIELD_W'(got >> lo) & mask;
      if (got_f !== exp_f[i]) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h",
                 $time, field_names[i], exp_f[i], got_f);
        fail_count++;
      end
      lo += w;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      video_total_reg    = VIDEO_TOTAL_RST;
      aperture_total_reg = APERTURE_TOTAL_RST;
      clear_counters();
      expected_snapshots.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_VIDEO_TOTAL) video_total_reg = cfg_data;
        else if (cfg_index == REG_APERTURE_TOTAL) aperture_total_reg = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_snapshots.size() == 0) begin
          $display("%0t: unexpected result item, expected none, actual %0h",
                   $time, out_tdata);
          fail_count++;
        end else begin
          compare_snapshot(expected_snapshots.pop_front(), out_tdata);
        end
      end
      if (in_tvalid && in_tready)
        account_event(in_tuser, in_tdata[0], in_tdata[3:1], in_tdata[35:4]);
    end
    pending <= expected_snapshots.size();
  end

endmodule

FILE: tb/sv/memory_usage_accounting_top_tb.sv
// Testbench top for the memory usage accounting block: clock, reset, stimulus and verdict.
module memory_usage_accounting_top_tb;
  import mua_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SIZE_W-1:0] SIZE_MAX  = '1;
  localparam logic [CFG_W-1:0]  TOTAL_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [0] in_video_domain, [3:1] pool_kind, [35:4] size_in_bytes
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [1:0] operation
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] status, [40:1] video_used, [80:41] video_free, [120:81] video_peak,
  // [160:121] aperture_used, [200:161] aperture_free, [232:201] active_count,
  // [264:233] surface_total, [296:265] texture_total, [328:297] cursor_total,
  // [360:329] failure_total
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending;
  int snd_idle_pct = 22;
  int rcv_idle_pct = 50;

  // sizes still allocated per domain, used to build matching frees
  logic [SIZE_W-1:0] video_allocs[$];
  logic [SIZE_W-1:0] aperture_allocs[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  memory_usage_accounting_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  memory_usage_accounting_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk)
    out_tready <= (rcv_idle_pct == 0) || ($urandom_range(99) >= rcv_idle_pct);

  task automatic push_event(logic [OP_W-1:0] op, logic video,
                            logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, size, kind, video};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drop valid and let every outstanding snapshot come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_totals(logic [CFG_W-1:0] video_total, logic [CFG_W-1:0] aperture_total);
    cfg_we    <= 1'b1;
    cfg_index <= REG_VIDEO_TOTAL;
    cfg_data  <= video_total;
    @(posedge clk);
    cfg_index <= REG_APERTURE_TOTAL;
    cfg_data  <= aperture_total;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(bit heavy);
    int r;
    r = $urandom_range(99);
    if (heavy) return (r < 90) ? SIZE_MAX : $urandom;
    if (r < 5) return '0;
    if (r < 15) return SIZE_MAX;
    if (r < 45) return $urandom_range(4096, 1);
    return $urandom;
  endfunction

  task automatic push_random(bit heavy);
    int r;
    int idx;
    logic video;
    logic [KIND_W-1:0] kind;
    logic [SIZE_W-1:0] size;
    r = $urandom_range(99);
    video = heavy ? ($urandom_range(99) < 95) : 1'($urandom_range(1));
    kind = KIND_W'($urandom_range(7));
    size = pick_size(heavy);
    if (heavy) r = (r < 90) ? 10 : r;
    if (r < 3) begin
      video_allocs.delete();
      aperture_allocs.delete();
      push_event(OP_INIT, video, kind, size);
    end else if (r < 48) begin
      if (video) video_allocs.push_back(size);
      else aperture_allocs.push_back(size);
      push_event(OP_ALLOC, video, kind, size);
    end else if (r < 80) begin
      // mostly give back a size that was really allocated in that domain
      if ($urandom_range(99) < 65) begin
        if (video && video_allocs.size() != 0) begin
          idx = $urandom_range(video_allocs.size() - 1);
          size = video_allocs[idx];
          video_allocs.delete(idx);
        end else if (!video && aperture_allocs.size() != 0) begin
          idx = $urandom_range(aperture_allocs.size() - 1);
          size = aperture_allocs[idx];
          aperture_allocs.delete(idx);
        end
      end
      push_event(OP_FREE, video, kind, size);
    end else begin
      push_event(OP_FAILURE, video, kind, size);
    end
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // events before init report not initialized
    push_event(OP_ALLOC, 1'b1, POOL_SMALL, 32'd100);
    push_event(OP_FREE, 1'b0, POOL_MEDIUM, 32'd100);
    push_event(OP_FAILURE, 1'b1, POOL_HUGE, SIZE_MAX);
    push_event(OP_INIT, 1'b0, POOL_SMALL, 32'd0);
    // every pool kind, both domains
    for (int k = 0; k < 8; k++)
      push_event(OP_ALLOC, k[0], k[2:0], k[0] ? 32'd4096 * k : 32'd0);
    // aperture alloc beyond what is free
    push_event(OP_ALLOC, 1'b0, POOL_HUGE, SIZE_MAX);
    // free larger than used
    push_event(OP_FREE, 1'b1, POOL_LARGE, SIZE_MAX);
    push_event(OP_FREE, 1'b0, POOL_SMALL, 32'd4096);
    push_event(OP_FAILURE, 1'b0, POOL_SMALL, 32'd0);
    push_event(OP_INIT, 1'b1, POOL_MEDIUM, 32'd55);
    // free with nothing outstanding
    push_event(OP_FREE, 1'b1, POOL_SMALL, 32'd8);
    push_event(OP_FAILURE, 1'b1, 3'd7, SIZE_MAX);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: begin snd_idle_pct = 22; rcv_idle_pct = 50; end
        1: begin snd_idle_pct = 50; rcv_idle_pct = 22; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      case (p)
        0: write_totals('0, '0);
        1: write_totals(TOTAL_MAX, TOTAL_MAX);
        3: write_totals(TOTAL_MAX, '0);
        4: write_totals(CFG_W'($urandom_range(32'h0100_0000)), TOTAL_MAX);
        default: write_totals(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}));
      endcase
      video_allocs.delete();
      aperture_allocs.delete();
      push_event(OP_INIT, 1'($urandom_range(1)), KIND_W'($urandom_range(7)), $urandom);
      // the heavy phase piles up maximum allocations to hit byte saturation
      n = (p == 3) ? 400 : 130;
      for (int i = 0; i < n; i++) begin
        if (i == n / 2) wait_drained();
        push_random(p == 3);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: memory_usage_accounting_top.f
hdl/mua_pkg.sv
hdl/mua_cfg.sv
hdl/mua_core.sv
hdl/memory_usage_accounting_top.sv
tb/sv/memory_usage_accounting_checker.sv
tb/sv/memory_usage_accounting_top_tb.sv
